// File: hdl/indexed_list_engine_defines.svh
// Assertion macros shared by the indexed list engine RTL.
// Depends on nothing; expects clk_i and rst_ni in the including module.
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define ILE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define ILE_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

// File: hdl/ile_pkg.sv
// Package for the indexed list engine: codes, widths and the cell command.
// Depends on nothing; used by every module of the block.
`default_nettype none

package ile_pkg;

  localparam int CapacityDef = 256;
  localparam int PosW        = 16;
  localparam int DataW       = 32;
  localparam int LenW        = 9;
  localparam int GrpSize     = 16;
  localparam int InDataW     = 48;
  localparam int OutDataW    = 48;

  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_HEAD   = 3'd1,
    OP_TAIL   = 3'd2,
    OP_AT     = 3'd3,
    OP_DELETE = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GATHER,
    S_REDUCE
  } state_e;

  // Command broadcast to every cell of the row in the cycle of acceptance.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic             rd;
    logic [PosW-1:0]  pos;
    logic [DataW-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

// File: hdl/ile_cell.sv
// One storage cell of the list row: holds the entry at a fixed position.
// Depends on ile_pkg for the command type.
`default_nettype none

module ile_cell #(
  parameter int Index = 0
) (
  input  logic                       clk_i,
  input  ile_pkg::cmd_t              cmd_i,
  input  logic [ile_pkg::DataW-1:0]  left_i,
  input  logic [ile_pkg::DataW-1:0]  right_i,
  output logic [ile_pkg::DataW-1:0]  value_o,
  output logic [ile_pkg::DataW-1:0]  hit_o
);
  import ile_pkg::*;

  localparam logic [PosW-1:0] MyPos = PosW'(Index);

  logic [DataW-1:0] value_q;
  logic [DataW-1:0] hit_q;

  // Inserts move the tail one place right, deletes pull it one place left.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins) begin
      if (MyPos > cmd_i.pos) begin
        value_q <= left_i;
      end else if (MyPos == cmd_i.pos) begin
        value_q <= cmd_i.value;
      end
    end else if (cmd_i.del && (MyPos >= cmd_i.pos)) begin
      value_q <= right_i;
    end
  end

  // A read captures the entry as it stood before this transaction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins || cmd_i.del || cmd_i.rd) begin
      hit_q <= (cmd_i.rd && (MyPos == cmd_i.pos)) ? value_q : '0;
    end
  end

  assign value_o = value_q;
  assign hit_o   = hit_q;

endmodule

`default_nettype wire

// File: hdl/ile_row.sv
// Row of list cells chained to their neighbours, with registered group ORs of read hits.
// Depends on ile_pkg and ile_cell.
`default_nettype none

module ile_row #(
  parameter int Capacity = ile_pkg::CapacityDef,
  parameter int NumGrp   = (Capacity + ile_pkg::GrpSize - 1) / ile_pkg::GrpSize
) (
  input  logic                       clk_i,
  input  ile_pkg::cmd_t              cmd_i,
  input  logic                       grp_en_i,
  output logic [ile_pkg::DataW-1:0]  grp_o [NumGrp]
);
  import ile_pkg::*;

  localparam int PadN = NumGrp * GrpSize;

  logic [DataW-1:0] val     [Capacity];
  logic [DataW-1:0] hit     [Capacity];
  logic [DataW-1:0] hit_pad [PadN];
  logic [DataW-1:0] grp_d   [NumGrp];
  logic [DataW-1:0] grp_q   [NumGrp];

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [DataW-1:0] left_w;
    logic [DataW-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = val[i-1];
    end
    if (i == Capacity - 1) begin : g_last
      assign right_w = val[i];
    end else begin : g_mid_r
      assign right_w = val[i+1];
    end
    ile_cell #(.Index(i)) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd_i),
      .left_i  (left_w),
      .right_i (right_w),
      .value_o (val[i]),
      .hit_o   (hit[i])
    );
  end

  for (genvar j = 0; j < PadN; j++) begin : g_pad
    if (j < Capacity) begin : g_real
      assign hit_pad[j] = hit[j];
    end else begin : g_zero
      assign hit_pad[j] = '0;
    end
  end

  // Only the addressed cell holds a non-zero hit, so OR acts as the select.
  for (genvar g = 0; g < NumGrp; g++) begin : g_grp
    always_comb begin
      grp_d[g] = '0;
      for (int k = 0; k < GrpSize; k++) begin
        grp_d[g] = grp_d[g] | hit_pad[g*GrpSize + k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (grp_en_i) begin
        grp_q[g] <= grp_d[g];
      end
    end
    assign grp_o[g] = grp_q[g];
  end

endmodule

`default_nettype wire

// File: hdl/indexed_list_engine.sv
// Top level of the indexed list engine: stream ports, control and result register.
// Depends on ile_pkg, ile_row and indexed_list_engine_defines.svh.
`default_nettype none

// The engine keeps an ordered list of up to CAPACITY signed 32-bit values in a
// row of cells, each cell holding the entry at its own position. Every input
// transaction carries an operation (read, insert at head, insert at tail,
// insert before a position, delete at a position) and yields exactly one
// result transaction with the value read, a status and the new list length.
// Inserts and deletes shift the whole row by one place in the cycle of
// acceptance, so they cost no more than a read. A read is returned through a
// two-level registered OR tree over groups of sixteen cells, and that tree
// sets the rate: the hit is captured in the cells, gathered into the group
// registers (group gather), then reduced into the result register (final
// reduce), and only then is the next operation taken. The result register lets
// a new transaction be accepted while the previous result still waits to be
// taken; the final reduce step stalls for as long as an untaken result sits
// there. No transaction is accepted while reset is asserted. A position
// beyond the list leaves it unchanged with an out-of-range status, and a read
// then returns -1; an insert into a full list is refused with a full status.
// Entry contents are undefined until written, so no clearing pass is needed
// after reset.
module indexed_list_engine #(
  parameter int CAPACITY = ile_pkg::CapacityDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [15:0] position, [47:16] data_value
  input  logic [ile_pkg::InDataW-1:0]   s_axis_tdata_i,
  // [2:0] operation
  input  logic [2:0]                    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [31:0] read_value, [40:32] list_length, [47:41] zero
  output logic [ile_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]                    m_axis_tuser_o
);
  import ile_pkg::*;

  `include "indexed_list_engine_defines.svh"

  localparam int CntW   = $clog2(CAPACITY + 1);
  localparam int NumGrp = (CAPACITY + GrpSize - 1) / GrpSize;

  state_e state_q, state_d;

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             accept;
  logic             load_out;
  logic             grp_en;
  cmd_t             cmd;
  status_e          status_d;
  logic             rd_ok_d;

  logic             rd_ok_q;
  status_e          status_q;
  logic [LenW-1:0]  len_q;

  logic             m_valid_q;
  logic [OutDataW-1:0] m_data_q;
  logic [1:0]       m_user_q;

  logic [DataW-1:0] grp [NumGrp];
  logic [DataW-1:0] read_or;

  logic [PosW-1:0]  in_pos;
  logic [DataW-1:0] in_value;
  logic [PosW-1:0]  cnt_pos;
  logic             full;

  assign in_pos   = s_axis_tdata_i[PosW-1:0];
  assign in_value = s_axis_tdata_i[PosW +: DataW];
  assign cnt_pos  = PosW'(cnt_q);
  assign full     = (cnt_q == CntW'(CAPACITY));

  assign s_axis_tready_o = rst_ni && (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Decode the operation into a row command, the status and the new length.
  always_comb begin
    cmd       = '0;
    cmd.value = in_value;
    cmd.pos   = in_pos;
    cnt_d     = cnt_q;
    status_d  = ST_DONE;
    rd_ok_d   = 1'b0;
    unique case (op_e'(s_axis_tuser_i))
      OP_READ: begin
        if (in_pos < cnt_pos) begin
          rd_ok_d = 1'b1;
          cmd.rd  = accept;
        end else begin
          status_d = ST_RANGE;
        end
      end
      OP_HEAD, OP_TAIL, OP_AT: begin
        if (op_e'(s_axis_tuser_i) == OP_HEAD) begin
          cmd.pos = '0;
        end else if (op_e'(s_axis_tuser_i) == OP_TAIL) begin
          cmd.pos = cnt_pos;
        end
        if (cmd.pos > cnt_pos) begin
          status_d = ST_RANGE;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          cmd.ins = accept;
          cnt_d   = cnt_q + CntW'(1);
        end
      end
      OP_DELETE: begin
        if (in_pos < cnt_pos) begin
          cmd.del = accept;
          cnt_d   = cnt_q - CntW'(1);
        end else begin
          status_d = ST_RANGE;
        end
      end
      default: begin
        // Codes without meaning leave the list as it is.
      end
    endcase
  end

  ile_row #(
    .Capacity (CAPACITY),
    .NumGrp   (NumGrp)
  ) u_row (
    .clk_i    (clk_i),
    .cmd_i    (cmd),
    .grp_en_i (grp_en),
    .grp_o    (grp)
  );

  // Final level of the read-back tree over the registered group results.
  always_comb begin
    read_or = '0;
    for (int g = 0; g < NumGrp; g++) begin
      read_or = read_or | grp[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The reduce step waits while the result register still holds an untaken result.
  always_comb begin
    state_d  = state_q;
    grp_en   = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_GATHER;
        end
      end
      S_GATHER: begin
        grp_en  = 1'b1;
        state_d = S_REDUCE;
      end
      S_REDUCE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  // Result fields known at acceptance wait here for the read-back value.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_ok_q  <= rd_ok_d;
      status_q <= status_d;
      len_q    <= LenW'(cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_data_q <= {(OutDataW - LenW - DataW)'(0), len_q, (rd_ok_q ? read_or : '1)};
      m_user_q <= status_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  `ILE_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CntW'(CAPACITY), "list length beyond capacity")
  `ILE_ASSERT_NEXT(a_cnt_hold, !accept, $stable(cnt_q), "list length changed without a transaction")
  `ILE_ASSERT_NEXT(a_load_valid, load_out, m_valid_q, "result register not valid after load")
  `ILE_ASSERT_NEXT(a_one_step, accept, !s_axis_tready_o, "second transaction taken during an operation")

endmodule

`default_nettype wire

// File: tb/indexed_list_engine_tb.sv
// Self-checking testbench for the indexed list engine: directed and random list operations.
// A shadow copy of the list predicts every reply; depends on ile_pkg and the engine RTL.
module indexed_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ile_pkg::*;

  localparam int Capacity    = CapacityDef;
  localparam int ClkPeriod   = 10;
  localparam int ResetCycles = 6;
  localparam int DrainCycles = 12;
  localparam int CycleLimit  = 400000;
  localparam int ReportLimit = 10;

  // Operation codes the engine does not define; they must leave the list alone.
  localparam logic [2:0]       OpUnusedLo  = 3'd5;
  localparam logic [2:0]       OpUnusedMid = 3'd6;
  localparam logic [2:0]       OpUnusedHi  = 3'd7;
  localparam logic [DataW-1:0] NoValue     = '1;

  typedef struct {
    logic [DataW-1:0] read_value;
    status_e          status;
    logic [LenW-1:0]  list_length;
  } list_reply_t;

  // Shadow of the list contents plus the queue of replies still owed by the engine.
  class list_shadow;
    logic [DataW-1:0] cells[$];
    list_reply_t      owed_replies[$];
    int unsigned      depth;
    int unsigned      mismatches;

    function new(int unsigned cap);
      depth      = cap;
      mismatches = 0;
    endfunction

    function int unsigned length();
      return cells.size();
    endfunction

    function int unsigned outstanding();
      return owed_replies.size();
    endfunction

    // The range check takes precedence over the full check.
    function status_e insert_cell(int unsigned at, logic [DataW-1:0] value);
      if (at > cells.size()) return ST_RANGE;
      if (cells.size() >= depth) return ST_FULL;
      cells.insert(at, value);
      return ST_DONE;
    endfunction

    function void note_request(logic [2:0] op, logic [PosW-1:0] pos, logic [DataW-1:0] value);
      list_reply_t r;
      int unsigned at;
      at           = pos;
      r.read_value = NoValue;
      r.status     = ST_DONE;
      case (op)
        OP_READ: begin
          if (at < cells.size()) r.read_value = cells[at];
          else r.status = ST_RANGE;
        end
        OP_HEAD:  r.status = insert_cell(0, value);
        OP_TAIL:  r.status = insert_cell(cells.size(), value);
        OP_AT:    r.status = insert_cell(at, value);
        OP_DELETE: begin
          if (at < cells.size()) cells.delete(at);
          else r.status = ST_RANGE;
        end
        default: ;
      endcase
      r.list_length = LenW'(cells.size());
      owed_replies.push_back(r);
    endfunction

    function void check_reply(logic [DataW-1:0] value, logic [1:0] status,
                              logic [LenW-1:0] len);
      list_reply_t want;
      if (owed_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("%0t: unexpected reply value=%h status=%0d length=%0d",
                   $realtime, value, status, len);
        return;
      end
      want = owed_replies.pop_front();
      if (value !== want.read_value || status !== want.status ||
          len !== want.list_length) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("%0t: reply mismatch: expected value=%h status=%0d length=%0d,",
                   $realtime, want.read_value, want.status, want.list_length,
                   " got value=%h status=%0d length=%0d", value, status, len);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [2:0]          s_axis_tuser = '0;
  logic                m_axis_tready = 1'b0;
  logic                s_axis_tready;
  logic                m_axis_tvalid;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;

  list_shadow shadow = new(Capacity);

  indexed_list_engine #(
    .CAPACITY(Capacity)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Values sampled at the edge are the pre-edge ones, so the handshake is race free.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      shadow.check_reply(m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[40:32]);
  end

  // Presents one request and returns in the time step of its acceptance. Valid stays
  // high on return so that back-to-back transactions need no second assignment.
  task automatic send_op(logic [2:0] op, logic [PosW-1:0] pos, logic [DataW-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {value, pos};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    shadow.note_request(op, pos, value);
  endtask

  // Mostly legal positions, some on the boundary, a few anywhere in the field.
  function automatic logic [PosW-1:0] pick_position(int unsigned len, bit for_insert);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) begin
      if (for_insert) return PosW'($urandom_range(len, 0));
      if (len == 0) return '0;
      return PosW'($urandom_range(len - 1, 0));
    end
    if (r < 90) return PosW'($urandom_range(len + 1, len));
    return PosW'($urandom_range(16'hFFFF, 0));
  endfunction

  task automatic send_random(int unsigned grow_pct, int unsigned shrink_pct);
    int unsigned r;
    int unsigned len;
    logic [2:0]  op;
    r   = $urandom_range(99);
    len = shadow.length();
    if (r < 3) begin
      op = 3'($urandom_range(OpUnusedHi, OpUnusedLo));
      send_op(op, PosW'($urandom_range(16'hFFFF, 0)), $urandom);
    end else if (r < 3 + grow_pct) begin
      case ($urandom_range(3))
        0:       op = OP_HEAD;
        1:       op = OP_TAIL;
        default: op = OP_AT;
      endcase
      send_op(op, pick_position(len, 1'b1), $urandom);
    end else if (r < 3 + grow_pct + shrink_pct) begin
      send_op(OP_DELETE, pick_position(len, 1'b0), $urandom);
    end else begin
      send_op(OP_READ, pick_position(len, 1'b0), $urandom);
    end
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase one: the sender seldom idles while the receiver mostly stalls.
    send_idle_pct  = 9;
    recv_stall_pct = 87;

    // Operations on an empty list are all out of range.
    send_op(OP_READ, 16'd0, 32'h1234_5678);
    send_op(OP_DELETE, 16'd0, 32'h0);
    send_op(OP_AT, 16'd1, 32'h0BAD_F00D);
    // Build a short list from the field extremes.
    send_op(OP_AT, 16'd0, 32'h8000_0000);
    send_op(OP_HEAD, 16'hFFFF, 32'h7FFF_FFFF);
    send_op(OP_TAIL, 16'hFFFF, 32'h0000_0000);
    send_op(OP_TAIL, 16'd0, 32'hFFFF_FFFF);
    send_op(OP_AT, 16'd2, 32'h5555_5555);
    send_op(OP_AT, 16'd5, 32'hAAAA_AAAA);
    send_op(OP_AT, 16'd7, 32'h1111_1111);
    send_op(OP_AT, 16'hFFFF, 32'h2222_2222);
    // Reads at both ends, just past the end and at the top of the position field.
    send_op(OP_READ, 16'd0, 32'hFFFF_FFFF);
    send_op(OP_READ, 16'd2, 32'h0);
    send_op(OP_READ, 16'd5, 32'h0);
    send_op(OP_READ, 16'd6, 32'h0);
    send_op(OP_READ, 16'hFFFF, 32'h0);
    // Undefined operation codes change nothing.
    send_op(OpUnusedLo, 16'hA5A5, 32'hDEAD_BEEF);
    send_op(OpUnusedMid, 16'h5A5A, 32'h0);
    send_op(OpUnusedHi, 16'h0000, 32'hFFFF_FFFF);
    // Deletes at the head, at the tail, and beyond the list.
    send_op(OP_DELETE, 16'd0, 32'h0);
    send_op(OP_DELETE, 16'd4, 32'h0);
    send_op(OP_DELETE, 16'd4, 32'h0);
    send_op(OP_DELETE, 16'hFFFF, 32'h0);
    send_op(OP_READ, 16'd3, 32'h0);

    repeat (50) send_random(45, 30);

    // Hold the sender off until the engine has answered everything.
    s_axis_tvalid <= 1'b0;
    while (shadow.outstanding() != 0) @(posedge clk_i);

    // Phase two: the roles swap; fill the list and push against the full limit.
    send_idle_pct  = 87;
    recv_stall_pct = 9;
    while (shadow.length() < Capacity) send_random(90, 3);
    repeat (12) send_random(75, 5);

    // Phase three: no idling on either side; drain the list down to half.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (shadow.length() > Capacity / 2) send_random(4, 85);
    repeat (20) send_random(40, 30);

    s_axis_tvalid <= 1'b0;
    while (shadow.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (shadow.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/ile_pkg.sv
hdl/ile_cell.sv
hdl/ile_row.sv
hdl/indexed_list_engine.sv
tb/indexed_list_engine_tb.sv
